### src/gpa_pkg.sv
package gpa_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W = COORD_W + 1;
   localparam int MAG_W = COORD_W;
   localparam int MASS_W = 32;
   localparam int CFG_W = 32;
   localparam int PROD_W = 2 * CFG_W;
   localparam int SQ_W = 66;
   localparam int ROOT_W = SQ_W / 2;
   localparam int RSQ_W = ROOT_W + 3;
   localparam int K_W = PROD_W + MASS_W;
   localparam int DEN_W = SQ_W + ROOT_W;
   localparam int NUM_W = K_W + MAG_W;
   localparam int QUO_W = 33;
   localparam int REM_W = DEN_W + QUO_W;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_GRAV_CONSTANT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BODY_RADIUS = 2'd2;

   localparam logic [CFG_W-1:0] GRAV_CONSTANT_RST = 32'd655;
   localparam logic [CFG_W-1:0] TIME_STEP_RST = 32'd65536;
   localparam logic [CFG_W-1:0] BODY_RADIUS_RST = 32'd655360;

   localparam int QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [MASS_W-1:0] mass;
   } diff_item_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

   typedef struct packed {
      logic [PROD_W-1:0] step_grav;
      logic [PROD_W-1:0] radius_sq;
   } cfg_derived_type;

endpackage

### src/gpa_queue.sv
module gpa_queue #(
   parameter int DEPTH = gpa_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic push,
   input gpa_pkg::diff_item_type push_item,
   input logic pop,
   output gpa_pkg::diff_item_type pop_item,
   output gpa_pkg::queue_status_type status
);
   import gpa_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   diff_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = entry_ff[rd_ptr_ff];
   assign status.full = (count_ff == CNT_W'(DEPTH));
   assign status.nonempty = (count_ff != '0);

endmodule

### src/gpa_front.sv
module gpa_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic signed [gpa_pkg::COORD_W-1:0] req_source_x,
   input logic signed [gpa_pkg::COORD_W-1:0] req_source_y,
   input logic signed [gpa_pkg::COORD_W-1:0] req_target_x,
   input logic signed [gpa_pkg::COORD_W-1:0] req_target_y,
   input logic [gpa_pkg::MASS_W-1:0] req_source_mass,
   input gpa_pkg::queue_status_type q_stat,
   output logic q_push,
   output gpa_pkg::diff_item_type q_item
);
   import gpa_pkg::*;

   logic valid_ff, valid_in;
   diff_item_type item_ff;
   logic accept;

   assign req_stall = valid_ff && q_stat.full;
   assign accept = req_valid && !req_stall;
   assign q_push = valid_ff && !q_stat.full;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // difference of two signed words needs one extra bit
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.dx <= {req_source_x[COORD_W-1], req_source_x}
                       - {req_target_x[COORD_W-1], req_target_x};
         item_ff.dy <= {req_source_y[COORD_W-1], req_source_y}
                       - {req_target_y[COORD_W-1], req_target_y};
         item_ff.mass <= req_source_mass;
      end
   end

   assign q_item = item_ff;

endmodule

### src/gpa_back.sv
module gpa_back (
   input logic clock,
   input logic reset,
   input gpa_pkg::diff_item_type q_item,
   input gpa_pkg::queue_status_type q_stat,
   output logic q_pop,
   input gpa_pkg::cfg_derived_type cfg,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic signed [gpa_pkg::COORD_W-1:0] rsp_accel_x,
   output logic signed [gpa_pkg::COORD_W-1:0] rsp_accel_y,
   output logic rsp_within_contact,
   output logic rsp_saturated
);
   import gpa_pkg::*;

   localparam int SQ_STEPS = SQ_W / 2;
   localparam int HALF_SQ = SQ_W / 2;

   typedef struct packed {
      logic contact;
      logic neg_x;
      logic neg_y;
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic [K_W-1:0] k;
      logic [SQ_W-1:0] s;
   } geo_type;

   typedef struct packed {
      logic contact;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
      logic [DEN_W-1:0] den;
      logic [NUM_W-1:0] rem_x;
      logic [NUM_W-1:0] rem_y;
      logic [QUO_W-1:0] q_x;
      logic [QUO_W-1:0] q_y;
   } div_type;

   logic adv;

   logic p1_valid_ff;
   logic p1_neg_x_ff, p1_neg_y_ff;
   logic [MAG_W-1:0] p1_mag_x_ff, p1_mag_y_ff;
   logic [2*MAG_W-1:0] p1_dx2_ff, p1_dy2_ff;
   logic [PROD_W-1:0] p1_kl_ff, p1_kh_ff;
   logic signed [DIFF_W-1:0] dx_neg, dy_neg;

   logic [SQ_W-1:0] s_sum;

   logic sq_valid_ff [SQ_STEPS+1];
   geo_type sq_geo_ff [SQ_STEPS+1];
   logic [RSQ_W-1:0] sq_rem_ff [SQ_STEPS+1];
   logic [ROOT_W-1:0] sq_root_ff [SQ_STEPS+1];

   logic m1_valid_ff;
   logic m1_contact_ff, m1_neg_x_ff, m1_neg_y_ff;
   logic [2*ROOT_W-1:0] m1_den_lo_ff, m1_den_hi_ff;
   logic [2*MAG_W-1:0] m1_px_ff [3];
   logic [2*MAG_W-1:0] m1_py_ff [3];

   logic m2_valid_ff;
   logic m2_contact_ff, m2_neg_x_ff, m2_neg_y_ff;
   logic [DEN_W-1:0] m2_den_ff;
   logic [NUM_W-1:0] m2_num_x_ff, m2_num_y_ff;

   logic dv_valid_ff [QUO_W+1];
   div_type dv_ff [QUO_W+1];

   logic out_valid_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff;
   logic out_contact_ff, out_sat_ff;

   logic [QUO_W-1:0] lim_x, lim_y, mag_out_x, mag_out_y;
   logic sat_x, sat_y;

   assign adv = !out_valid_ff || !rsp_stall;
   assign q_pop = adv && q_stat.nonempty;

   assign dx_neg = -q_item.dx;
   assign dy_neg = -q_item.dy;

   // stage 1: magnitudes, squares, mass times step times constant
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= q_stat.nonempty;
         p1_neg_x_ff <= q_item.dx[DIFF_W-1];
         p1_neg_y_ff <= q_item.dy[DIFF_W-1];
         p1_mag_x_ff <= q_item.dx[DIFF_W-1] ? dx_neg[MAG_W-1:0] : q_item.dx[MAG_W-1:0];
         p1_mag_y_ff <= q_item.dy[DIFF_W-1] ? dy_neg[MAG_W-1:0] : q_item.dy[MAG_W-1:0];
         p1_dx2_ff <= (q_item.dx[DIFF_W-1] ? dx_neg[MAG_W-1:0] : q_item.dx[MAG_W-1:0])
                      * (q_item.dx[DIFF_W-1] ? dx_neg[MAG_W-1:0] : q_item.dx[MAG_W-1:0]);
         p1_dy2_ff <= (q_item.dy[DIFF_W-1] ? dy_neg[MAG_W-1:0] : q_item.dy[MAG_W-1:0])
                      * (q_item.dy[DIFF_W-1] ? dy_neg[MAG_W-1:0] : q_item.dy[MAG_W-1:0]);
         p1_kl_ff <= cfg.step_grav[CFG_W-1:0] * q_item.mass;
         p1_kh_ff <= cfg.step_grav[PROD_W-1:CFG_W] * q_item.mass;
      end
   end

   assign s_sum = SQ_W'(p1_dx2_ff) + SQ_W'(p1_dy2_ff);

   // stage 2: squared distance, contact test, full mass product
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_valid_ff[0] <= p1_valid_ff;
         sq_geo_ff[0].s <= s_sum;
         sq_geo_ff[0].contact <= (s_sum <= {cfg.radius_sq, 2'b00});
         sq_geo_ff[0].k <= K_W'(p1_kl_ff) + (K_W'(p1_kh_ff) << CFG_W);
         sq_geo_ff[0].neg_x <= p1_neg_x_ff;
         sq_geo_ff[0].neg_y <= p1_neg_y_ff;
         sq_geo_ff[0].mag_x <= p1_mag_x_ff;
         sq_geo_ff[0].mag_y <= p1_mag_y_ff;
         sq_rem_ff[0] <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   // square root, one result bit per stage
   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      logic [RSQ_W-1:0] cur, trial;
      assign cur = {sq_rem_ff[i][RSQ_W-3:0], sq_geo_ff[i].s[SQ_W-1-2*i -: 2]};
      assign trial = {{(RSQ_W-ROOT_W-2){1'b0}}, sq_root_ff[i], 2'b01};
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[i+1] <= sq_valid_ff[i];
            sq_geo_ff[i+1] <= sq_geo_ff[i];
            if (cur >= trial) begin
               sq_rem_ff[i+1] <= cur - trial;
               sq_root_ff[i+1] <= {sq_root_ff[i][ROOT_W-2:0], 1'b1};
            end else begin
               sq_rem_ff[i+1] <= cur;
               sq_root_ff[i+1] <= {sq_root_ff[i][ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   // partial products of denominator and numerators
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= sq_valid_ff[SQ_STEPS];
         m1_contact_ff <= sq_geo_ff[SQ_STEPS].contact;
         m1_neg_x_ff <= sq_geo_ff[SQ_STEPS].neg_x;
         m1_neg_y_ff <= sq_geo_ff[SQ_STEPS].neg_y;
         m1_den_lo_ff <= sq_geo_ff[SQ_STEPS].s[HALF_SQ-1:0] * sq_root_ff[SQ_STEPS];
         m1_den_hi_ff <= sq_geo_ff[SQ_STEPS].s[SQ_W-1:HALF_SQ] * sq_root_ff[SQ_STEPS];
         for (int j = 0; j < 3; j++) begin
            m1_px_ff[j] <= sq_geo_ff[SQ_STEPS].k[j*MAG_W +: MAG_W]
                           * sq_geo_ff[SQ_STEPS].mag_x;
            m1_py_ff[j] <= sq_geo_ff[SQ_STEPS].k[j*MAG_W +: MAG_W]
                           * sq_geo_ff[SQ_STEPS].mag_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m2_valid_ff <= m1_valid_ff;
         m2_contact_ff <= m1_contact_ff;
         m2_neg_x_ff <= m1_neg_x_ff;
         m2_neg_y_ff <= m1_neg_y_ff;
         m2_den_ff <= DEN_W'(m1_den_lo_ff) + (DEN_W'(m1_den_hi_ff) << HALF_SQ);
         m2_num_x_ff <= NUM_W'(m1_px_ff[0]) + (NUM_W'(m1_px_ff[1]) << MAG_W)
                        + (NUM_W'(m1_px_ff[2]) << (2 * MAG_W));
         m2_num_y_ff <= NUM_W'(m1_py_ff[0]) + (NUM_W'(m1_py_ff[1]) << MAG_W)
                        + (NUM_W'(m1_py_ff[2]) << (2 * MAG_W));
      end
   end

   // quotient overflow test, then restoring division one bit per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= m2_valid_ff;
         dv_ff[0].contact <= m2_contact_ff;
         dv_ff[0].neg_x <= m2_neg_x_ff;
         dv_ff[0].neg_y <= m2_neg_y_ff;
         dv_ff[0].den <= m2_den_ff;
         dv_ff[0].ovf_x <= (REM_W'(m2_num_x_ff) >= {m2_den_ff, {QUO_W{1'b0}}});
         dv_ff[0].ovf_y <= (REM_W'(m2_num_y_ff) >= {m2_den_ff, {QUO_W{1'b0}}});
         dv_ff[0].rem_x <= m2_num_x_ff;
         dv_ff[0].rem_y <= m2_num_y_ff;
         dv_ff[0].q_x <= '0;
         dv_ff[0].q_y <= '0;
      end
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      logic [REM_W-1:0] dsh, ext_x, ext_y, sub_x, sub_y;
      logic ge_x, ge_y;
      assign dsh = REM_W'(dv_ff[i].den) << (QUO_W - 1 - i);
      assign ext_x = REM_W'(dv_ff[i].rem_x);
      assign ext_y = REM_W'(dv_ff[i].rem_y);
      assign ge_x = ext_x >= dsh;
      assign ge_y = ext_y >= dsh;
      assign sub_x = ext_x - dsh;
      assign sub_y = ext_y - dsh;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[i+1] <= dv_valid_ff[i];
            dv_ff[i+1].contact <= dv_ff[i].contact;
            dv_ff[i+1].neg_x <= dv_ff[i].neg_x;
            dv_ff[i+1].neg_y <= dv_ff[i].neg_y;
            dv_ff[i+1].ovf_x <= dv_ff[i].ovf_x;
            dv_ff[i+1].ovf_y <= dv_ff[i].ovf_y;
            dv_ff[i+1].den <= dv_ff[i].den;
            dv_ff[i+1].rem_x <= ge_x ? sub_x[NUM_W-1:0] : dv_ff[i].rem_x;
            dv_ff[i+1].rem_y <= ge_y ? sub_y[NUM_W-1:0] : dv_ff[i].rem_y;
            dv_ff[i+1].q_x <= {dv_ff[i].q_x[QUO_W-2:0], ge_x};
            dv_ff[i+1].q_y <= {dv_ff[i].q_y[QUO_W-2:0], ge_y};
         end
      end
   end

   // clip to the signed range and apply the sign
   always_comb begin
      lim_x = dv_ff[QUO_W].neg_x ? QUO_W'(33'h0_8000_0000) : QUO_W'(33'h0_7FFF_FFFF);
      lim_y = dv_ff[QUO_W].neg_y ? QUO_W'(33'h0_8000_0000) : QUO_W'(33'h0_7FFF_FFFF);
      sat_x = dv_ff[QUO_W].ovf_x || (dv_ff[QUO_W].q_x > lim_x);
      sat_y = dv_ff[QUO_W].ovf_y || (dv_ff[QUO_W].q_y > lim_y);
      mag_out_x = sat_x ? lim_x : dv_ff[QUO_W].q_x;
      mag_out_y = sat_y ? lim_y : dv_ff[QUO_W].q_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_valid_ff[QUO_W];
         out_contact_ff <= dv_ff[QUO_W].contact;
         if (dv_ff[QUO_W].contact) begin
            out_x_ff <= '0;
            out_y_ff <= '0;
            out_sat_ff <= 1'b0;
         end else begin
            out_x_ff <= dv_ff[QUO_W].neg_x ? -mag_out_x[COORD_W-1:0] : mag_out_x[COORD_W-1:0];
            out_y_ff <= dv_ff[QUO_W].neg_y ? -mag_out_y[COORD_W-1:0] : mag_out_y[COORD_W-1:0];
            out_sat_ff <= sat_x || sat_y;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_accel_x = out_x_ff;
   assign rsp_accel_y = out_y_ff;
   assign rsp_within_contact = out_contact_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

### src/pairwise_gravity_acceleration.sv
// Pairwise gravity: for each transfer of a source point, a target point and the
// source mass, returns dt*G*m*(source-target)/d^3 in Q16.16, clipped to 32 bits,
// or zero with within_contact set when d^2 <= 4*radius^2. One item is accepted
// per cycle and one result leaves per cycle while req_stall and rsp_stall stay
// low. The arithmetic pipeline holds a 33-stage square-root pipeline and a
// 33-stage division pipeline. A queue (four entries by default) separates the
// input stage from the arithmetic pipeline. Write the registers only while idle.
module pairwise_gravity_acceleration #(
   parameter int QUEUE_DEPTH = gpa_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic csr_wr_en,
   input logic [gpa_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [gpa_pkg::CFG_W-1:0] csr_wr_data,
   input logic req_valid,
   output logic req_stall,
   input logic signed [gpa_pkg::COORD_W-1:0] req_source_x,
   input logic signed [gpa_pkg::COORD_W-1:0] req_source_y,
   input logic signed [gpa_pkg::COORD_W-1:0] req_target_x,
   input logic signed [gpa_pkg::COORD_W-1:0] req_target_y,
   input logic [gpa_pkg::MASS_W-1:0] req_source_mass,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic signed [gpa_pkg::COORD_W-1:0] rsp_accel_x,
   output logic signed [gpa_pkg::COORD_W-1:0] rsp_accel_y,
   output logic rsp_within_contact,
   output logic rsp_saturated
);
   import gpa_pkg::*;

   logic [CFG_W-1:0] grav_ff, grav_in;
   logic [CFG_W-1:0] step_ff, step_in;
   logic [CFG_W-1:0] radius_ff, radius_in;
   logic [PROD_W-1:0] step_grav_ff;
   logic [PROD_W-1:0] radius_sq_ff;
   cfg_derived_type cfg;

   queue_status_type q_stat;
   logic q_push, q_pop;
   diff_item_type push_item, pop_item;

   always_comb begin
      grav_in = grav_ff;
      step_in = step_ff;
      radius_in = radius_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRAV_CONSTANT: grav_in = csr_wr_data;
            REG_TIME_STEP: step_in = csr_wr_data;
            REG_BODY_RADIUS: radius_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= GRAV_CONSTANT_RST;
         step_ff <= TIME_STEP_RST;
         radius_ff <= BODY_RADIUS_RST;
      end else begin
         grav_ff <= grav_in;
         step_ff <= step_in;
         radius_ff <= radius_in;
      end
   end

   always_ff @(posedge clock) begin
      step_grav_ff <= step_ff * grav_ff;
      radius_sq_ff <= radius_ff * radius_ff;
   end

   assign cfg.step_grav = step_grav_ff;
   assign cfg.radius_sq = radius_sq_ff;

   gpa_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_source_x(req_source_x),
      .req_source_y(req_source_y),
      .req_target_x(req_target_x),
      .req_target_y(req_target_y),
      .req_source_mass(req_source_mass),
      .q_stat(q_stat),
      .q_push(q_push),
      .q_item(push_item)
   );

   gpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_item(push_item),
      .pop(q_pop),
      .pop_item(pop_item),
      .status(q_stat)
   );

   gpa_back u_back (
      .clock(clock),
      .reset(reset),
      .q_item(pop_item),
      .q_stat(q_stat),
      .q_pop(q_pop),
      .cfg(cfg),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accel_x(rsp_accel_x),
      .rsp_accel_y(rsp_accel_y),
      .rsp_within_contact(rsp_within_contact),
      .rsp_saturated(rsp_saturated)
   );

   a_contact_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_within_contact |->
         rsp_accel_x == '0 && rsp_accel_y == '0 && !rsp_saturated)
      else $error("contact result not zero");

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_accel_x == 32'sh7FFF_FFFF || rsp_accel_x == 32'sh8000_0000 ||
         rsp_accel_y == 32'sh7FFF_FFFF || rsp_accel_y == 32'sh8000_0000)
      else $error("saturated flag without clipped component");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue push while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.nonempty)
      else $error("queue pop while empty");

endmodule
